// File: hdl/set_pkg.sv
// ----------------------------------------------------------------------------
// set_pkg: shared types and constants for the sobel edge threshold block
// widths, register indexes and the front/back job word
// ----------------------------------------------------------------------------
`default_nettype none
package set_pkg;
  localparam int MaxWidth = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  typedef logic [9:0] gray_t;

  // one edge job: 8 gray values in neighbourhood order plus tags
  typedef struct packed {
    gray_t tl, t, tr, l, r, bl, b, br;
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic last;
  } job_t;
endpackage
`default_nettype wire

// File: hdl/set_front.sv
// ----------------------------------------------------------------------------
// set_front: raster front end
// gray conversion, line stores, 3x3 window and generation of up to four jobs
// ----------------------------------------------------------------------------
`default_nettype none
module set_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [11:0]      image_width,
  input  wire logic [12:0]      image_height,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [31:0]      pixel_word,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output set_pkg::job_t         job
);
  import set_pkg::*;

  typedef enum logic [2:0] {
    S_IN   = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  gray_t upper_line [MaxWidth];
  gray_t middle_line [MaxWidth];
  gray_t win [9];
  gray_t rd_up, rd_mid, vb;
  logic [ColW:0] column_count;
  logic [RowW:0] row_count;
  logic [ColW-1:0] c;
  logic [RowW-1:0] r;
  logic [3:0] pend;
  logic [ColW:0] w_eff;
  logic [RowW:0] h_eff;
  logic [ColW:0] col_fix;
  logic [RowW:0] row_fix;
  logic [ColW:0] col_adv;
  logic [RowW:0] row_adv;
  logic row_ge1, row_ge2;
  gray_t vm, vt;
  logic [3:0] want;
  logic [1:0] sel;
  logic [3:0] sel_oh, remain;

  always_comb begin
    w_eff = (image_width == 12'd0) ? (ColW+1)'(1) :
            ({1'b0, image_width} > 13'(MaxWidth)) ? (ColW+1)'(MaxWidth) :
            (ColW+1)'(image_width);
    h_eff = (image_height == 13'd0) ? (RowW+1)'(1) :
            (image_height > 13'(MaxHeight)) ? (RowW+1)'(MaxHeight) :
            (RowW+1)'(image_height);
    col_fix = column_count;
    row_fix = row_count;
    if (column_count >= w_eff) begin
      col_fix = '0;
      row_fix = row_count + 1'b1;
    end
    if (row_fix >= h_eff) row_fix = '0;
    // position of the next word, wrapped at the end of the row and frame
    col_adv = col_fix + 1'b1;
    row_adv = row_fix;
    if (col_adv >= w_eff) begin
      col_adv = '0;
      row_adv = row_fix + 1'b1;
      if (row_adv >= h_eff) row_adv = '0;
    end
  end

  assign in_ready = (state == S_IN);
  assign vm = row_ge1 ? rd_mid : vb;
  assign vt = row_ge2 ? rd_up : vm;

  // job selection: 0 left above, 1 right edge above, 2 left last row, 3 right last row
  always_comb begin
    sel = 2'd0;
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    sel_oh = 4'b0001 << sel;
    remain = pend & ~sel_oh;
  end

  always_comb begin
    logic right_edge, last_row;
    right_edge = (sel == 2'd1) || (sel == 2'd3);
    last_row = (sel == 2'd2) || (sel == 2'd3);
    if (!last_row) begin
      job.tl = right_edge ? win[3] : win[0];
      job.l  = right_edge ? win[4] : win[1];
      job.bl = right_edge ? win[5] : win[2];
      job.t  = right_edge ? win[6] : win[3];
      job.b  = right_edge ? win[8] : win[5];
      job.tr = win[6];
      job.r  = win[7];
      job.br = win[8];
      job.y  = r - 1'b1;
    end else begin
      job.tl = right_edge ? win[4] : win[1];
      job.l  = right_edge ? win[5] : win[2];
      job.bl = right_edge ? win[5] : win[2];
      job.t  = right_edge ? win[7] : win[4];
      job.b  = right_edge ? win[8] : win[5];
      job.tr = win[7];
      job.r  = win[8];
      job.br = win[8];
      job.y  = r;
    end
    job.x = right_edge ? c : c - 1'b1;
    job.last = (remain == 4'd0);
  end
  assign job_valid = (state == S_EMIT) && (pend != 4'd0);

  always_comb begin
    logic is_last_col, is_last_row;
    is_last_col = ((ColW+1)'(c) == w_eff - 1'b1);
    is_last_row = ((RowW+1)'(r) == h_eff - 1'b1);
    want[0] = row_ge1 && (c != '0);
    want[1] = row_ge1 && is_last_col;
    want[2] = is_last_row && (c != '0);
    want[3] = is_last_row && is_last_col;
  end

  // line stores: read on accept, written back in the cycle after with the new data
  always_ff @(posedge clk) begin
    if (state == S_IN && in_valid) begin
      rd_up <= upper_line[col_fix[ColW-1:0]];
      rd_mid <= middle_line[col_fix[ColW-1:0]];
    end
    if (state == S_READ) begin
      upper_line[c] <= vm;
      middle_line[c] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      column_count <= '0;
      row_count <= '0;
      pend <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      case (state)
        S_IN: begin
          if (in_valid) begin
            c <= col_fix[ColW-1:0];
            r <= row_fix[RowW-1:0];
            row_ge1 <= (row_fix != '0);
            row_ge2 <= (row_fix > (RowW+1)'(1));
            vb <= 10'(pixel_word[31:24]) + 10'(pixel_word[23:16]) + 10'(pixel_word[15:8]);
            column_count <= col_adv;
            row_count <= row_adv;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (c == '0) begin
            for (int i = 0; i < 3; i++) begin
              win[i*3] <= vt;
              win[i*3+1] <= vm;
              win[i*3+2] <= vb;
            end
          end else begin
            for (int i = 0; i < 6; i++) win[i] <= win[i+3];
            win[6] <= vt;
            win[7] <= vm;
            win[8] <= vb;
          end
          pend <= want;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (pend == 4'd0) state <= S_IN;
          else if (job_ready) begin
            pend <= remain;
            if (remain == 4'd0) state <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/set_queue.sv
// ----------------------------------------------------------------------------
// set_queue: four-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module set_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire set_pkg::job_t wr_job,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output set_pkg::job_t      rd_job
);
  import set_pkg::*;

  job_t mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic push, pop;

  assign wr_ready = (count != 3'd4);
  assign rd_valid = (count != 3'd0);
  assign rd_job = mem[rptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

// File: hdl/set_back.sv
// ----------------------------------------------------------------------------
// set_back: gradient, magnitude and threshold for one job
// squares, then a bit-serial square root, then an output register
// ----------------------------------------------------------------------------
`default_nettype none
module set_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    keep_threshold,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire set_pkg::job_t job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [10:0]        out_x,
  output logic [11:0]        out_y,
  output logic [31:0]        out_pixel,
  output logic               last_of_run
);
  import set_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQ   = 4'b0010,
    B_ROOT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state;
  logic signed [12:0] gx, gy;
  logic [11:0] ax, ay;
  logic [23:0] sx, sy;
  logic [25:0] v;
  logic [12:0] root;
  logic [3:0] step;
  logic [ColW-1:0] x;
  logic [RowW-1:0] y;
  logic last;
  logic [7:0] g, mag;

  always_comb begin
    gx = (13'(job.bl) + 13'({job.b, 1'b0}) + 13'(job.br))
       - (13'(job.tl) + 13'({job.t, 1'b0}) + 13'(job.tr));
    gy = (13'(job.tr) + 13'({job.r, 1'b0}) + 13'(job.br))
       - (13'(job.tl) + 13'({job.l, 1'b0}) + 13'(job.bl));
  end

  assign job_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);

  // restoring root: one result bit per cycle, 13 steps
  always_comb begin
    mag = (root > 13'd255) ? 8'd255 : root[7:0];
    g = 8'd255 - mag;
    if (g < keep_threshold) g = 8'd0;
  end

  logic [26:0] rem;
  logic [26:0] part;
  assign part = {rem[24:0], v[25:24]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            ax <= gx[12] ? 12'(-gx) : 12'(gx);
            ay <= gy[12] ? 12'(-gy) : 12'(gy);
            x <= job.x;
            y <= job.y;
            last <= job.last;
            state <= B_SQ;
          end
        end
        B_SQ: begin
          sx <= ax * ax;
          sy <= ay * ay;
          state <= B_ROOT;
          step <= 4'd13;
          root <= '0;
          rem <= '0;
        end
        B_ROOT: begin
          if (step == 4'd13) begin
            v <= 26'(sx) + 26'(sy);
            step <= 4'd12;
          end else begin
            if (part >= 27'({root, 2'b01})) begin
              rem <= part - 27'({root, 2'b01});
              root <= {root[11:0], 1'b1};
            end else begin
              rem <= part;
              root <= {root[11:0], 1'b0};
            end
            v <= {v[23:0], 2'b00};
            if (step == 4'd0) state <= B_OUT;
            else step <= step - 1'b1;
          end
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_x = x;
  assign out_y = y;
  assign out_pixel = {8'hff, g, g, g};
  assign last_of_run = last;
endmodule
`default_nettype wire

// File: hdl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold: 3x3 sobel edge detector with inverted threshold
// top level: configuration registers, front end, job queue and back end
// ----------------------------------------------------------------------------
// pixels arrive one word at a time in raster order; the gray level is the sum
// of the three upper bytes. the front end accepts a word, reads the line stores
// and shifts the window, then hands on its results one at a time; it takes no
// new word until all are handed on. the back end takes one job at a time and
// passes it through absolute value, squares, a bit-serial square root and an
// output register that holds the result until out_ready.
// line stores hold no reset value; results are tagged with column and row.
`default_nettype none
module sobel_edge_threshold (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_x,
  output logic [11:0]      out_y,
  output logic [31:0]      out_pixel,
  output logic             last_of_run
);
  import set_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  keep_threshold;
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 12'd640;
      image_height <= 13'd480;
      keep_threshold <= 8'd254;
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth: image_width <= cfg_data[11:0];
        RegHeight: image_height <= cfg_data;
        RegThresh: keep_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  set_front u_front (
    .clk, .rst, .image_width, .image_height,
    .in_valid, .in_ready, .pixel_word,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  set_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
  );

  set_back u_back (
    .clk, .rst, .keep_threshold,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .out_ready, .out_x, .out_y, .out_pixel, .last_of_run
  );
endmodule
`default_nettype wire
